>>> src/mwc_pkg.sv
// Package for the lag-4 multiply-with-carry generator.
// Holds opcodes, sequencer states, core handshake structs and step constants.
// No dependencies.
package mwc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned PROD_W = 2 * WORD_W;
    localparam int unsigned LAGS   = 4;

    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd29943828;
    localparam logic [WORD_W-1:0] BAD_RANGE    = 32'h8000_0000;
    localparam logic [4:0]        WARMUP_STEPS = 5'd19;

    typedef enum logic [1:0] {
        OP_RESEED = 2'd0,
        OP_RAW    = 2'd1,
        OP_RANGE  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_STEP,
        ST_SCALE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [1:0]        op;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
    } t_core_req;

    typedef struct packed {
        logic              idle;
        logic              valid;
        logic [WORD_W-1:0] value;
    } t_core_rsp;

    // Multiplier applied to lag word number tap in one step.
    function automatic logic [WORD_W-1:0] step_coef(input logic [1:0] tap);
        logic [WORD_W-1:0] c;
        unique case (tap)
            2'd0:    c = 32'd5115;
            2'd1:    c = 32'd1776;
            2'd2:    c = 32'd1492;
            default: c = 32'd2111111111;
        endcase
        return c;
    endfunction

endpackage

>>> src/mwc_mul.sv
// Shared 32x32 multiplier with a registered 64-bit product.
// Depends on mwc_pkg.
module mwc_mul (
    input  logic                         i_clk,
    input  logic [mwc_pkg::WORD_W-1:0]   i_a,
    input  logic [mwc_pkg::WORD_W-1:0]   i_b,
    output logic [mwc_pkg::PROD_W-1:0]   o_prod
);
    import mwc_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

>>> src/mwc_core.sv
// Generator state and sequencer: seeding, MWC steps and range scaling,
// all through one shared multiplier. Depends on mwc_pkg and mwc_mul.
module mwc_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mwc_pkg::t_core_req           i_req,
    input  logic [mwc_pkg::WORD_W-1:0]   i_seed,
    input  logic                         i_res_ready,
    output mwc_pkg::t_core_rsp           o_rsp
);
    import mwc_pkg::*;

    t_state            r_state, n_state;
    logic [2:0]        r_phase, n_phase;
    logic [4:0]        r_steps, n_steps;
    logic              r_ranged, n_ranged;
    logic              r_quiet, n_quiet;
    logic [WORD_W-1:0] r_lag [LAGS];
    logic [WORD_W-1:0] n_lag [LAGS];
    logic [WORD_W-1:0] r_carry, n_carry;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_lo, n_lo;
    logic [WORD_W-1:0] r_n, n_n;
    logic [WORD_W-1:0] r_result, n_result;

    logic [WORD_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sum;
    logic [1:0]        tap;
    logic [1:0]        seed_slot;

    mwc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign tap       = ~r_phase[1:0];
    assign seed_slot = r_phase[1:0] - 2'd1;
    assign sum       = r_acc + prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= '0;
            r_steps  <= '0;
            r_ranged <= 1'b0;
            r_quiet  <= 1'b0;
            r_carry  <= '0;
            for (int i = 0; i < LAGS; i++) begin
                r_lag[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_steps  <= n_steps;
            r_ranged <= n_ranged;
            r_quiet  <= n_quiet;
            r_carry  <= n_carry;
            r_lag    <= n_lag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_lo     <= n_lo;
        r_n      <= n_n;
        r_result <= n_result;
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_steps  = r_steps;
        n_ranged = r_ranged;
        n_quiet  = r_quiet;
        n_lag    = r_lag;
        n_carry  = r_carry;
        n_acc    = r_acc;
        n_lo     = r_lo;
        n_n      = r_n;
        n_result = r_result;
        mul_a    = '0;
        mul_b    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    n_phase = '0;
                    case (i_req.op)
                        OP_RESEED: begin
                            n_state  = ST_SEED;
                            n_ranged = 1'b0;
                            n_quiet  = 1'b1;
                        end
                        OP_RAW: begin
                            n_state  = ST_STEP;
                            n_steps  = 5'd1;
                            n_ranged = 1'b0;
                            n_quiet  = 1'b0;
                        end
                        OP_RANGE: begin
                            n_lo = i_req.lo;
                            n_n  = i_req.hi - i_req.lo + 32'd1;
                            if (i_req.hi == i_req.lo) begin
                                n_result = i_req.lo;
                                n_state  = ST_DONE;
                            end else if (i_req.hi < i_req.lo) begin
                                n_result = BAD_RANGE;
                                n_state  = ST_DONE;
                            end else begin
                                n_state  = ST_STEP;
                                n_steps  = 5'd1;
                                n_ranged = 1'b1;
                                n_quiet  = 1'b0;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            // Seed chain: issue s*K each cycle, the registered product lands in the next cycle.
            ST_SEED: begin
                mul_a = (r_phase == 3'd0) ? i_seed : prod[WORD_W-1:0];
                mul_b = SEED_MULT;
                if (r_phase == 3'd5) begin
                    n_carry = prod[WORD_W-1:0];
                    n_state = ST_STEP;
                    n_phase = '0;
                    n_steps = WARMUP_STEPS;
                end else begin
                    if (r_phase != 3'd0) begin
                        n_lag[seed_slot] = prod[WORD_W-1:0];
                    end
                    n_phase = r_phase + 3'd1;
                end
            end

            // Phases 0..3 issue lag3..lag0 products, phase 4 commits.
            ST_STEP: begin
                mul_a = r_lag[tap];
                mul_b = step_coef(tap);
                if (r_phase == 3'd0) begin
                    n_acc   = PROD_W'(r_carry);
                    n_phase = 3'd1;
                end else if (r_phase != 3'd4) begin
                    n_acc   = sum;
                    n_phase = r_phase + 3'd1;
                end else begin
                    n_lag[3] = r_lag[2];
                    n_lag[2] = r_lag[1];
                    n_lag[1] = r_lag[0];
                    n_lag[0] = sum[WORD_W-1:0];
                    n_carry  = sum[PROD_W-1:WORD_W];
                    n_phase  = '0;
                    if (r_steps == 5'd1) begin
                        if (r_ranged) begin
                            n_state = ST_SCALE;
                        end else if (r_quiet) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_result = sum[WORD_W-1:0];
                            n_state  = ST_DONE;
                        end
                    end else begin
                        n_steps = r_steps - 5'd1;
                    end
                end
            end

            ST_SCALE: begin
                mul_a = r_lag[0];
                mul_b = r_n;
                if (r_phase == 3'd0) begin
                    n_phase = 3'd1;
                end else begin
                    n_result = prod[PROD_W-1:WORD_W] + r_lo;
                    n_state  = ST_DONE;
                end
            end

            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp.idle  = (r_state == ST_IDLE);
    assign o_rsp.valid = (r_state == ST_DONE);
    assign o_rsp.value = r_result;

endmodule

>>> src/multiply_with_carry_rng.sv
// Top level of the lag-4 multiply-with-carry random number generator.
// Depends on mwc_pkg and mwc_core; holds the seed register and output register.
//
// Usage:
//   Seed register: write i_cfg_wdata with i_cfg_we high; it takes effect at the
//   next reseed transaction. Write only while the block is idle.
//   Input stream: s_axis_tuser carries the opcode (0 reseed, 1 raw, 2 ranged),
//   s_axis_tdata carries range_min (low) and range_max (high). Opcode 3 is
//   dropped. Reseed and dropped transactions give no output.
//   Output stream: m_axis_tdata carries random_value.
// Timing:
//   One generator step runs through phases 0..4 on the shared multiplier.
//   Raw word: one generator step, then the result goes from ST_DONE to the output register.
//   Ranged word: one step plus one extra multiply in ST_SCALE; bad bounds skip to ST_DONE.
//   Reseed: seeding phases 0..5, then 19 warm-up steps.
//   s_axis_tready is high only while the sequencer is idle.
// Reset: synchronous, active low; clears lags, carry, seed and output valid.
//   After reset all words are zero until a reseed is done.
// Stall: a result waits in the output register while a new transaction is
//   taken; the next result then waits in the core until the register frees.
module multiply_with_carry_rng (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mwc_pkg::WORD_W-1:0]   i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [63:0]                  s_axis_tdata,   // range_min, range_max
    input  logic [1:0]                   s_axis_tuser,   // opcode
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [mwc_pkg::WORD_W-1:0]   m_axis_tdata    // random_value
);
    import mwc_pkg::*;

    logic [WORD_W-1:0] r_seed;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_data;
    t_core_req         req;
    t_core_rsp         rsp;
    logic              res_ready;

    assign req.start = s_axis_tvalid & s_axis_tready;
    assign req.op    = s_axis_tuser;
    assign req.lo    = s_axis_tdata[WORD_W-1:0];
    assign req.hi    = s_axis_tdata[2*WORD_W-1:WORD_W];

    assign res_ready = ~r_out_valid | m_axis_tready;

    mwc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_seed      (r_seed),
        .i_res_ready (res_ready),
        .o_rsp       (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= rsp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && rsp.valid) begin
            r_out_data <= rsp.value;
        end
    end

    assign s_axis_tready = rsp.idle;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> dv/multiply_with_carry_rng_tb.sv
// Self-checking testbench for multiply_with_carry_rng: stream stimulus, seed writes,
// and a bit-exact lag-4 multiply-with-carry predictor in a small scoreboard class.
// Depends on mwc_pkg and the multiply_with_carry_rng RTL.
import mwc_pkg::*;

class mwc_word_checker;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] lags [LAGS];
    logic [WORD_W-1:0] carry;
    logic [WORD_W-1:0] expected_words [$];
    int unsigned       mismatches;

    function new();
        seed        = '0;
        carry       = '0;
        mismatches  = 0;
        foreach (lags[i]) lags[i] = '0;
    endfunction

    function void set_seed(input logic [WORD_W-1:0] value);
        seed = value;
    endfunction

    function logic [WORD_W-1:0] step_generator();
        logic [PROD_W-1:0] sum;
        sum = 64'd2111111111 * lags[3] + 64'd1492 * lags[2]
            + 64'd1776 * lags[1] + 64'd5115 * lags[0] + carry;
        lags[3] = lags[2];
        lags[2] = lags[1];
        lags[1] = lags[0];
        lags[0] = sum[WORD_W-1:0];
        carry   = sum[PROD_W-1:WORD_W];
        return lags[0];
    endfunction

    function void note_request(input logic [1:0] op, input logic [WORD_W-1:0] lo,
                               input logic [WORD_W-1:0] hi);
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] word;
        logic [PROD_W-1:0] prod;
        case (op)
            OP_RESEED: begin
                s = seed;
                for (int i = 0; i < LAGS; i++) begin
                    s = s * SEED_MULT;
                    lags[i] = s;
                end
                s = s * SEED_MULT;
                carry = s;
                for (int i = 0; i < WARMUP_STEPS; i++) void'(step_generator());
            end
            OP_RAW: begin
                expected_words.push_back(step_generator());
            end
            OP_RANGE: begin
                if (hi == lo) begin
                    expected_words.push_back(lo);
                end else if (hi < lo) begin
                    expected_words.push_back(BAD_RANGE);
                end else begin
                    span = hi - lo + 32'd1;
                    word = step_generator();
                    prod = {32'd0, word} * {32'd0, span};
                    expected_words.push_back(prod[PROD_W-1:WORD_W] + lo);
                end
            end
            default: ;
        endcase
    endfunction

    function void check_word(input logic [WORD_W-1:0] actual);
        logic [WORD_W-1:0] want;
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction: %h", actual);
            return;
        end
        want = expected_words.pop_front();
        if (actual !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("random_value mismatch: expected %h, got %h", want, actual);
        end
    endfunction

    function int unsigned pending();
        return expected_words.size();
    endfunction
endclass

module multiply_with_carry_rng_tb;

    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 120;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [WORD_W-1:0] i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata;   // range_min, range_max
    logic [1:0]        s_axis_tuser;   // opcode
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [WORD_W-1:0] m_axis_tdata;   // random_value

    mwc_word_checker words;

    bit          stall_req  = 1'b0;
    bit          stall_seen = 1'b0;
    int unsigned stall_left = 0;
    int unsigned rx_cycles  = 0;
    int unsigned rx_mode    = 0;

    multiply_with_carry_rng i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: checks each result transaction, stalls on its own pattern.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready)
            words.check_word(m_axis_tdata);
        rx_cycles <= rx_cycles + 1;
        if (stall_seen != stall_req) begin
            stall_seen    <= stall_req;
            stall_left    <= 400;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_cycles % 256 == 0) rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (rx_cycles[3:2] != 2'b00);
            endcase
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [WORD_W-1:0] lo,
                             input logic [WORD_W-1:0] hi);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {hi, lo};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words.note_request(op, lo, hi);
    endtask

    task automatic idle_gap(input int unsigned cycles);
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= 2'($urandom);
        s_axis_tdata  <= {$urandom, $urandom};
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (words.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_seed(input logic [WORD_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        words.set_seed(value);
    endtask

    function automatic void random_request(output logic [1:0] op,
                                           output logic [WORD_W-1:0] lo,
                                           output logic [WORD_W-1:0] hi);
        int unsigned pick;
        logic [WORD_W-1:0] t;
        pick = $urandom_range(0, 99);
        lo   = $urandom;
        hi   = $urandom;
        if (pick < 4) begin
            op = OP_RESEED;
        end else if (pick < 8) begin
            op = OP_UNUSED;
        end else if (pick < 52) begin
            op = OP_RAW;
        end else begin
            op = OP_RANGE;
            case ($urandom_range(0, 9))
                0: hi = lo;
                1: begin
                    lo = $urandom_range(1, 32'hFFFF_FFFF);
                    hi = $urandom_range(0, lo - 1);
                end
                2: hi = lo + $urandom_range(1, 16);
                3: begin
                    lo = '0;
                    hi = '1;
                end
                4: lo = '0;
                default: if (lo > hi) begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
            endcase
        end
    endfunction

    task automatic run_phase(input logic [WORD_W-1:0] seed, input int unsigned n_items,
                             input bit gaps_on, input bit squeeze);
        int unsigned       sent;
        int unsigned       burst;
        logic [1:0]        op;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        sent  = 0;
        burst = 0;
        load_seed(seed);
        send_item(OP_RESEED, $urandom, $urandom);
        while (sent < n_items) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if (gaps_on) idle_gap($urandom_range(1, 8));
            end
            random_request(op, lo, hi);
            send_item(op, lo, hi);
            burst--;
            if (op != OP_UNUSED) sent++;
            if (squeeze && sent == 5) stall_req <= ~stall_req;
        end
    endtask

    initial begin
        words = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_RAW;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero state before any reseed
        send_item(OP_RAW, '0, '0);
        send_item(OP_RANGE, 32'd0, 32'hFFFF_FFFE);
        send_item(OP_RANGE, '0, '0);
        send_item(OP_RANGE, 32'hFFFF_FFFF, 32'd0);
        send_item(OP_UNUSED, '1, '1);
        send_item(OP_RAW, '1, '1);

        load_seed(32'hFFFF_FFFF);
        send_item(OP_RESEED, '1, '1);
        send_item(OP_RAW, '0, '0);
        send_item(OP_RANGE, 32'd0, 32'hFFFF_FFFF);
        send_item(OP_RANGE, 32'd0, 32'hFFFF_FFFE);
        send_item(OP_RANGE, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_item(OP_RANGE, 32'd5, 32'd6);
        send_item(OP_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_RANGE, 32'd1, 32'd0);
        send_item(OP_UNUSED, '0, '0);
        send_item(OP_RESEED, '0, '0);
        send_item(OP_RAW, '0, '0);
        send_item(OP_RANGE, 32'h0000_1000, 32'hF000_0000);

        load_seed(32'd0);
        send_item(OP_RESEED, '0, '0);
        send_item(OP_RAW, '0, '0);
        send_item(OP_RANGE, 32'd3, 32'd1000);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       run_phase(32'd1, 220, 1'b1, 1'b0);
                1:       run_phase(32'h8000_0000, 220, 1'b0, 1'b0);
                2:       run_phase(32'hFFFF_FFFF, 220, 1'b1, 1'b1);
                3:       run_phase(32'd0, 40, 1'b1, 1'b0);
                5:       run_phase($urandom, 220, 1'b1, 1'b1);
                default: run_phase($urandom, 220, (p % 3) != 1, 1'b0);
            endcase
        end

        s_axis_tvalid <= 1'b0;
        while (words.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (words.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
